// ===== hdl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg: shared constants and types for the vector normalizer
// Widths of the magnitude, square root and divider pipelines, plus the
// sideband structures that travel between the pipeline modules.
// ----------------------------------------------------------------------------
package vn_pkg;

	// Bits of each input component that take part in the computation.
	localparam int CW      = 32;
	// Fractional bits of each unit component.
	localparam int FRAC    = 30;
	// Port widths fixed by the interface.
	localparam int IO_W    = 32;
	localparam int CFG_W   = 16;

	localparam int MAG_W   = CW;
	localparam int SUM_W   = 2 * CW;
	localparam int REM_W   = MAG_W + 1;
	localparam int Q_W     = FRAC + 1;

	// Cycles from the accepting edge to the edge that takes the result.
	localparam int LATENCY = MAG_W + Q_W + 6;

	// Operands that ride alongside the magnitude computation.
	typedef struct packed {
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] az;
		logic          nx;
		logic          ny;
		logic          nz;
	} side_t;

	// Control that travels down the divider pipeline.
	typedef struct packed {
		logic valid;
		logic skip;
		logic nx;
		logic ny;
		logic nz;
	} dctl_t;

endpackage

// ===== hdl/vn_sqrt.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined floor square root
// One result bit per stage; the operands of the request ride along.
// ----------------------------------------------------------------------------
module vn_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [vn_pkg::SUM_W-1:0]    in_sum,
	input  vn_pkg::side_t               in_side,
	output logic                        out_valid,
	output logic [vn_pkg::MAG_W-1:0]    out_mag,
	output vn_pkg::side_t               out_side
);

	logic                       v_sk    [vn_pkg::MAG_W];
	logic [vn_pkg::REM_W-1:0]   rem_sk  [vn_pkg::MAG_W];
	logic [vn_pkg::MAG_W-1:0]   root_sk [vn_pkg::MAG_W];
	logic [vn_pkg::SUM_W-1:0]   n_sk    [vn_pkg::MAG_W];
	vn_pkg::side_t              side_sk [vn_pkg::MAG_W];

	for (genvar i = 0; i < vn_pkg::MAG_W; i++) begin : g_step
		logic                       prev_v;
		logic [vn_pkg::REM_W-1:0]   prev_rem;
		logic [vn_pkg::MAG_W-1:0]   prev_root;
		logic [vn_pkg::SUM_W-1:0]   prev_n;
		vn_pkg::side_t              prev_side;
		logic [vn_pkg::REM_W+1:0]   cur;
		logic [vn_pkg::REM_W+1:0]   sub;
		logic [vn_pkg::REM_W+1:0]   diff;
		logic                       ge;

		if (i == 0) begin : g_first
			assign prev_v    = in_valid;
			assign prev_rem  = '0;
			assign prev_root = '0;
			assign prev_n    = in_sum;
			assign prev_side = in_side;
		end else begin : g_next
			assign prev_v    = v_sk[i-1];
			assign prev_rem  = rem_sk[i-1];
			assign prev_root = root_sk[i-1];
			assign prev_n    = n_sk[i-1];
			assign prev_side = side_sk[i-1];
		end

		always_comb begin
			cur  = {prev_rem, prev_n[vn_pkg::SUM_W-1 -: 2]};
			sub  = {1'b0, prev_root, 2'b01};
			diff = cur - sub;
			ge   = (cur >= sub);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[i] <= 1'b0;
			end else begin
				v_sk[i] <= prev_v;
			end
		end

		// The remainder never exceeds twice the partial root, so it fits REM_W bits.
		always_ff @(posedge clk) begin
			rem_sk[i]  <= ge ? diff[vn_pkg::REM_W-1:0] : cur[vn_pkg::REM_W-1:0];
			root_sk[i] <= {prev_root[vn_pkg::MAG_W-2:0], ge};
			n_sk[i]    <= {prev_n[vn_pkg::SUM_W-3:0], 2'b00};
			side_sk[i] <= prev_side;
		end
	end

	assign out_valid = v_sk[vn_pkg::MAG_W-1];
	assign out_mag   = root_sk[vn_pkg::MAG_W-1];
	assign out_side  = side_sk[vn_pkg::MAG_W-1];

endmodule

// ===== hdl/vn_div.sv =====
// ----------------------------------------------------------------------------
// vn_div: three-lane pipelined restoring divider
// Computes (a << FRAC) / mag for each lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vn_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vn_pkg::dctl_t                     in_ctl,
	input  logic [vn_pkg::MAG_W-1:0]          in_mag,
	input  logic [2:0][vn_pkg::MAG_W-1:0]     in_a,
	output vn_pkg::dctl_t                     out_ctl,
	output logic [2:0][vn_pkg::Q_W-1:0]       out_q
);

	vn_pkg::dctl_t                       ctl_sk [vn_pkg::Q_W];
	logic [vn_pkg::MAG_W-1:0]            mag_sk [vn_pkg::Q_W];
	logic [2:0][vn_pkg::MAG_W-1:0]       r_sk   [vn_pkg::Q_W];
	logic [2:0][vn_pkg::Q_W-1:0]         q_sk   [vn_pkg::Q_W];

	for (genvar k = 0; k < vn_pkg::Q_W; k++) begin : g_step
		vn_pkg::dctl_t                   prev_ctl;
		logic [vn_pkg::MAG_W-1:0]        prev_mag;
		logic [2:0][vn_pkg::MAG_W:0]     cur;
		logic [2:0][vn_pkg::Q_W-1:0]     prev_q;

		if (k == 0) begin : g_first
			assign prev_ctl = in_ctl;
			assign prev_mag = in_mag;
			assign prev_q   = '0;
			for (genvar l = 0; l < 3; l++) begin : g_ln
				assign cur[l] = {1'b0, in_a[l]};
			end
		end else begin : g_next
			assign prev_ctl = ctl_sk[k-1];
			assign prev_mag = mag_sk[k-1];
			assign prev_q   = q_sk[k-1];
			for (genvar l = 0; l < 3; l++) begin : g_ln
				assign cur[l] = {r_sk[k-1][l], 1'b0};
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic                     ge;
			logic [vn_pkg::MAG_W:0]   diff;

			always_comb begin
				diff = cur[l] - {1'b0, prev_mag};
				ge   = (cur[l] >= {1'b0, prev_mag});
			end

			// The remainder stays below mag, so it fits MAG_W bits.
			always_ff @(posedge clk) begin
				r_sk[k][l] <= ge ? diff[vn_pkg::MAG_W-1:0] : cur[l][vn_pkg::MAG_W-1:0];
				q_sk[k][l] <= {prev_q[l][vn_pkg::Q_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sk[k] <= '0;
			end else begin
				ctl_sk[k] <= prev_ctl;
			end
		end

		always_ff @(posedge clk) begin
			mag_sk[k] <= prev_mag;
		end
	end

	assign out_ctl = ctl_sk[vn_pkg::Q_W-1];
	assign out_q   = q_sk[vn_pkg::Q_W-1];

endmodule

// ===== hdl/vector3_normalize_top.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_top: fixed-point 3D vector normalizer
// A request accepted at one edge delivers its result on the done strobe
// after passing through 4 front stages, 32 root stages, 1 threshold stage,
// 31 divider stages and 1 output stage.
// Throughput: one request per cycle; busy is always low.
// Reset clears all valid bits and the threshold register to zero.
// ----------------------------------------------------------------------------
module vector3_normalize_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [31:0]          vec_x,
	input  logic signed [31:0]          vec_y,
	input  logic signed [31:0]          vec_z,
	input  logic                        min_magnitude_we,
	input  logic [15:0]                 min_magnitude_wdata,
	output logic                        done,
	output logic signed [31:0]          unit_x,
	output logic signed [31:0]          unit_y,
	output logic signed [31:0]          unit_z,
	output logic                        skipped
);

	// The pipeline never stalls, since results cannot be held off, so every
	// request is taken as soon as it is offered.
	assign busy = 1'b0;

	logic                      accept;
	assign accept = start && !busy;

	// Threshold register. Write only while no request is in flight; unchecked.
	logic [vn_pkg::CFG_W-1:0]  min_mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mag_q <= '0;
		end else if (min_magnitude_we) begin
			min_mag_q <= min_magnitude_wdata;
		end
	end

	// Stage 1: take the low CW bits of each component as signed, and split
	// them into magnitude and sign. The most negative value maps to 2^(CW-1),
	// which fits the unsigned magnitude field.
	logic                      v_s1;
	vn_pkg::side_t             side_s1;
	logic [vn_pkg::CW-1:0]     cx, cy, cz;

	always_comb begin
		cx = vec_x[vn_pkg::CW-1:0];
		cy = vec_y[vn_pkg::CW-1:0];
		cz = vec_z[vn_pkg::CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.nx <= cx[vn_pkg::CW-1];
		side_s1.ny <= cy[vn_pkg::CW-1];
		side_s1.nz <= cz[vn_pkg::CW-1];
		side_s1.ax <= cx[vn_pkg::CW-1] ? (~cx + 1'b1) : cx;
		side_s1.ay <= cy[vn_pkg::CW-1] ? (~cy + 1'b1) : cy;
		side_s1.az <= cz[vn_pkg::CW-1] ? (~cz + 1'b1) : cz;
	end

	// Stage 2: the three squares, one multiplier per component.
	logic                      v_s2;
	vn_pkg::side_t             side_s2;
	logic [vn_pkg::SUM_W-1:0]  sqx_s2, sqy_s2, sqz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		sqx_s2  <= side_s1.ax * side_s1.ax;
		sqy_s2  <= side_s1.ay * side_s1.ay;
		sqz_s2  <= side_s1.az * side_s1.az;
	end

	// Stages 3 and 4: the sum of squares, one wide add per stage. The sum is
	// at most 3 * 2^(2CW-2), so it never wraps.
	logic                      v_s3, v_s4;
	vn_pkg::side_t             side_s3, side_s4;
	logic [vn_pkg::SUM_W-1:0]  sxy_s3, sqz_s3, sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		sxy_s3  <= sqx_s2 + sqy_s2;
		sqz_s3  <= sqz_s2;
		side_s4 <= side_s3;
		sum_s4  <= sxy_s3 + sqz_s3;
	end

	// Floor square root of the sum: the magnitude.
	logic                      v_rt;
	logic [vn_pkg::MAG_W-1:0]  mag_rt;
	vn_pkg::side_t             side_rt;

	vn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_sum    (sum_s4),
		.in_side   (side_s4),
		.out_valid (v_rt),
		.out_mag   (mag_rt),
		.out_side  (side_rt)
	);

	// Threshold stage. A skipped request still runs down the divider, whose
	// quotients are then discarded; this also covers the zero vector, so a
	// zero divisor never reaches the output. Both sides are widened to the
	// sum width so the compare holds whenever SUM_W is at least CFG_W.
	vn_pkg::dctl_t                   ctl_c;
	logic [vn_pkg::MAG_W-1:0]        mag_c;
	logic [2:0][vn_pkg::MAG_W-1:0]   a_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c <= '0;
		end else begin
			ctl_c.valid <= v_rt;
			ctl_c.skip  <= (vn_pkg::SUM_W'(mag_rt) <= vn_pkg::SUM_W'(min_mag_q));
			ctl_c.nx    <= side_rt.nx;
			ctl_c.ny    <= side_rt.ny;
			ctl_c.nz    <= side_rt.nz;
		end
	end

	always_ff @(posedge clk) begin
		mag_c  <= mag_rt;
		a_c[0] <= side_rt.ax;
		a_c[1] <= side_rt.ay;
		a_c[2] <= side_rt.az;
	end

	// Divide each component magnitude by the vector magnitude. The floor root
	// is never below any component, so each quotient is at most 2^FRAC.
	vn_pkg::dctl_t                   ctl_d;
	logic [2:0][vn_pkg::Q_W-1:0]     q_d;

	vn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_c),
		.in_mag  (mag_c),
		.in_a    (a_c),
		.out_ctl (ctl_d),
		.out_q   (q_d)
	);

	// Output stage: restore the signs and zero the units of skipped requests.
	logic [vn_pkg::IO_W-1:0]   ux, uy, uz;

	always_comb begin
		ux = vn_pkg::IO_W'(q_d[0]);
		uy = vn_pkg::IO_W'(q_d[1]);
		uz = vn_pkg::IO_W'(q_d[2]);
		if (ctl_d.nx) begin
			ux = -ux;
		end
		if (ctl_d.ny) begin
			uy = -uy;
		end
		if (ctl_d.nz) begin
			uz = -uz;
		end
		if (ctl_d.skip) begin
			ux = '0;
			uy = '0;
			uz = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		unit_x  <= ux;
		unit_y  <= uy;
		unit_z  <= uz;
		skipped <= ctl_d.skip;
	end

endmodule

// ===== hdl/vn_check.sv =====
// ----------------------------------------------------------------------------
// vn_check: port-level checks for the vector normalizer
// Watches the top-level ports and flags timing and range violations.
// ----------------------------------------------------------------------------
module vn_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic signed [31:0]  unit_x,
	input  logic signed [31:0]  unit_y,
	input  logic signed [31:0]  unit_z,
	input  logic                done,
	input  logic                skipped
);

	// Every result comes from a request accepted a fixed number of cycles ago.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, vn_pkg::LATENCY))
		else $error("result without a matching request");

	// A skipped result carries zero units.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && skipped) |-> (unit_x == 0 && unit_y == 0 && unit_z == 0))
		else $error("skipped result with nonzero units");

	// Normalized components never leave the range of plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !skipped) |->
			(unit_x <= 32'sh4000_0000 && unit_x >= -32'sh4000_0000 &&
			 unit_y <= 32'sh4000_0000 && unit_y >= -32'sh4000_0000 &&
			 unit_z <= 32'sh4000_0000 && unit_z >= -32'sh4000_0000))
		else $error("unit component out of range");

	// The pipeline never refuses a request.
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind vector3_normalize_top vn_check u_vn_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.unit_x  (unit_x),
	.unit_y  (unit_y),
	.unit_z  (unit_z),
	.done    (done),
	.skipped (skipped)
);
